// File: design/complex_fir_filter_defines.svh
// Assertion macros for the complex FIR filter.
// Used by the top level; depends on nothing else.
`ifndef COMPLEX_FIR_FILTER_DEFINES_SVH
`define COMPLEX_FIR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// Implication in the same cycle, disabled while reset is asserted.
`define CFIR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication in the next cycle, disabled while reset is asserted.
`define CFIR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CFIR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define CFIR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: design/cfir_pkg.sv
// Shared types, widths and the round/saturate function of the complex FIR filter.
// Depends on nothing; every file but the defines header imports it.
`default_nettype none

package cfir_pkg;

    // Filter length and register file size.
    localparam int NUM_TAPS  = 8;
    localparam int TAP_REGS  = 8;
    localparam int TAP_IDX_W = $clog2(TAP_REGS);
    localparam int CFG_IDX_W = TAP_IDX_W + 1;
    localparam int CFG_W     = 32;
    localparam int DLY_D     = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;

    // Arithmetic widths: 16x16 products, one extra bit for the sum of two,
    // then growth for the accumulation over all taps.
    localparam int SMP_W  = 16;
    localparam int MUL_W  = 2 * SMP_W;
    localparam int PROD_W = MUL_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS);
    localparam int FRAC_W = 15;
    localparam int SH_W   = ACC_W + 1 - FRAC_W;

    localparam int ROUND_BIAS = 16384;
    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(-32768);
    localparam logic signed [SMP_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [SMP_W-1:0] OUT_MIN = 16'sh8000;

    // Complex Q1.15 value, real part in the upper half.
    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_cplx;

    // Complex product of one tap and one sample, full precision.
    typedef struct packed {
        logic signed [PROD_W-1:0] re;
        logic signed [PROD_W-1:0] im;
    } t_prod;

    // One rounded and saturated part with its clip flag.
    typedef struct packed {
        logic signed [SMP_W-1:0] val;
        logic                    clip;
    } t_rs;

    // Round half toward plus infinity, drop the fraction, clip to Q1.15.
    function automatic t_rs round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]  biased;
        logic signed [SH_W-1:0] sh;
        t_rs                    r;
        biased = (ACC_W+1)'(acc) + (ACC_W+1)'(ROUND_BIAS);
        sh     = biased[ACC_W:FRAC_W];
        if (sh > SAT_MAX) begin
            r.val  = OUT_MAX;
            r.clip = 1'b1;
        end else if (sh < SAT_MIN) begin
            r.val  = OUT_MIN;
            r.clip = 1'b1;
        end else begin
            r.val  = sh[SMP_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/cfir_tap_regs.sv
// Tap register file of the complex FIR filter, written through the config port.
// Depends on cfir_pkg.
`default_nettype none

module cfir_tap_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cfir_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cfir_pkg::CFG_W-1:0]     i_cfg_data,
    output cfir_pkg::t_cplx                     o_taps [cfir_pkg::TAP_REGS]
);
    import cfir_pkg::*;

    t_cplx r_taps [TAP_REGS];
    logic  idx_ok;

    // Writes beyond the register list are dropped.
    assign idx_ok = i_cfg_idx < CFG_IDX_W'(TAP_REGS);

    // Taps clear at reset and load on a write to their index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAP_REGS; k++) begin
                r_taps[k] <= '0;
            end
        end else if (i_cfg_we && idx_ok) begin
            r_taps[i_cfg_idx[TAP_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    assign o_taps = r_taps;

endmodule

`default_nettype wire

// File: design/cfir_cmac_lane.sv
// One complex multiply lane: tap times sample, registered at full precision.
// Depends on cfir_pkg.
`default_nettype none

module cfir_cmac_lane (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire cfir_pkg::t_cplx i_smp,
    input  wire cfir_pkg::t_cplx i_tap,
    output cfir_pkg::t_prod o_prod
);
    import cfir_pkg::*;

    logic signed [MUL_W-1:0] ac;
    logic signed [MUL_W-1:0] bd;
    logic signed [MUL_W-1:0] ad;
    logic signed [MUL_W-1:0] bc;
    t_prod                   n_prod;
    t_prod                   r_prod;

    // (a + jb)(c + jd) = (ac - bd) + j(ad + bc)
    assign ac = i_smp.re * i_tap.re;
    assign bd = i_smp.im * i_tap.im;
    assign ad = i_smp.re * i_tap.im;
    assign bc = i_smp.im * i_tap.re;

    always_comb begin
        n_prod.re = PROD_W'(ac) - PROD_W'(bd);
        n_prod.im = PROD_W'(ad) + PROD_W'(bc);
    end

    // Product register advances with the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: design/cfir_sum_round.sv
// Adds the lane products and rounds and saturates both parts to Q1.15.
// Depends on cfir_pkg.
`default_nettype none

module cfir_sum_round (
    input  wire cfir_pkg::t_prod i_prod [cfir_pkg::NUM_TAPS],
    output cfir_pkg::t_rs   o_re,
    output cfir_pkg::t_rs   o_im
);
    import cfir_pkg::*;

    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;

    // Exact sum over all taps.
    always_comb begin
        acc_re = '0;
        acc_im = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            acc_re = acc_re + ACC_W'(i_prod[k].re);
            acc_im = acc_im + ACC_W'(i_prod[k].im);
        end
    end

    assign o_re = round_sat(acc_re);
    assign o_im = round_sat(acc_im);

endmodule

`default_nettype wire

// File: design/complex_fir_filter.sv
// Complex FIR filter with complex taps: an accepted item goes to the product
// register, then the output one; one item is taken every cycle unless stalled.
// The rate is set by the parallel multiply lanes, one per tap, feeding the
// product register, and the adder and rounding stage feeding the output register.
// Synchronous active-low reset clears the taps, the delay line and all valid bits.
// Top level; depends on cfir_pkg, cfir_tap_regs, cfir_cmac_lane, cfir_sum_round.
`default_nettype none
`include "complex_fir_filter_defines.svh"

module complex_fir_filter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cfir_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cfir_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [15:0]             i_sample_re,
    input  wire logic signed [15:0]             i_sample_im,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [15:0]                  o_out_re,
    output logic signed [15:0]                  o_out_im,
    output logic                                o_saturated
);
    import cfir_pkg::*;

    t_cplx taps [TAP_REGS];
    t_cplx win  [NUM_TAPS];
    t_prod prod [NUM_TAPS];
    t_cplx smp;
    t_rs   sum_re;
    t_rs   sum_im;
    logic  adv;
    logic  acc;
    logic  r_p_valid;
    logic  r_o_valid;
    logic signed [SMP_W-1:0] r_out_re;
    logic signed [SMP_W-1:0] r_out_im;
    logic                    r_out_sat;

    // The whole pipeline moves when the output register is free or being taken.
    assign adv     = !r_o_valid || !i_stall;
    assign o_stall = !adv;
    assign acc     = i_valid && adv;

    assign smp.re = i_sample_re;
    assign smp.im = i_sample_im;

    cfir_tap_regs u_taps (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_taps     (taps)
    );

    // Window: stored older samples, oldest first, then the incoming sample.
    generate
        if (NUM_TAPS > 1) begin : g_dly
            t_cplx r_dly [DLY_D];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int k = 0; k < DLY_D; k++) begin
                        r_dly[k] <= '0;
                    end
                end else if (acc) begin
                    for (int k = 0; k < DLY_D - 1; k++) begin
                        r_dly[k] <= r_dly[k+1];
                    end
                    r_dly[DLY_D-1] <= smp;
                end
            end

            for (genvar k = 0; k < DLY_D; k++) begin : g_win
                assign win[k] = r_dly[k];
            end
        end
    endgenerate

    assign win[NUM_TAPS-1] = smp;

    // One multiply lane per tap.
    generate
        for (genvar k = 0; k < NUM_TAPS; k++) begin : g_lane
            cfir_cmac_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_smp  (win[k]),
                .i_tap  (taps[k]),
                .o_prod (prod[k])
            );
        end
    endgenerate

    cfir_sum_round u_sum (
        .i_prod (prod),
        .o_re   (sum_re),
        .o_im   (sum_im)
    );

    // Valid bits of the product and output stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= i_valid;
            r_o_valid <= r_p_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_re  <= sum_re.val;
            r_out_im  <= sum_im.val;
            r_out_sat <= sum_re.clip || sum_im.clip;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_saturated = r_out_sat;

    // An accepted item is held in the product stage on the next cycle.
    `CFIR_ASSERT_NEXT(a_acc_to_prod, i_clk, i_rst_n, acc, r_p_valid, "accepted item lost")
    // A full product stage reaches the output register when the pipe moves.
    `CFIR_ASSERT_NEXT(a_prod_to_out, i_clk, i_rst_n, r_p_valid && adv, r_o_valid,
        "product stage item lost")
    // A stalled pipe keeps its product stage item.
    `CFIR_ASSERT_NEXT(a_prod_hold, i_clk, i_rst_n, r_p_valid && !adv, r_p_valid,
        "product stage dropped under stall")
    // A clipped result has at least one part at a bound.
    `CFIR_ASSERT_SAME(a_sat_bound, i_clk, i_rst_n, r_o_valid && r_out_sat,
        r_out_re == OUT_MAX || r_out_re == OUT_MIN || r_out_im == OUT_MAX ||
        r_out_im == OUT_MIN, "saturated flag without a clipped part")

endmodule

`default_nettype wire

// File: tb/cfir_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the complex FIR filter testbench: a bit-exact predictor of the
// filter and the queue of results it expects. Depends on cfir_pkg.
package cfir_tb_pkg;

    import cfir_pkg::*;

    // One filtered output as the block should present it.
    typedef struct {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
        logic                    sat;
    } t_fir_result;

    class fir_scoreboard;

        logic [CFG_W-1:0] coeff[TAP_REGS];
        t_cplx            history[DLY_D];
        t_fir_result      awaited[$];
        int               mismatches;
        int               checked;

        function new();
            int k;
            for (k = 0; k < TAP_REGS; k++) coeff[k] = '0;
            for (k = 0; k < DLY_D; k++) history[k] = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Register writes beyond the tap file are dropped by the block.
        function void write_reg(int unsigned idx, logic [CFG_W-1:0] data);
            if (idx < TAP_REGS) coeff[idx] = data;
        endfunction

        // Round half up from Q.30 to Q1.15 and clip; bit 16 is the clip flag.
        function bit [16:0] to_q15(longint acc);
            longint r;
            r = (acc + 64'sd16384) >>> 15;
            if (r > 32767) return {1'b1, 16'h7fff};
            if (r < -32768) return {1'b1, 16'h8000};
            return {1'b0, r[15:0]};
        endfunction

        // An accepted sample: filter it against the stored history and queue the result.
        function void take_sample(logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im);
            t_cplx       window[NUM_TAPS];
            longint      a, b, c, d, acc_re, acc_im;
            bit [16:0]   part_re, part_im;
            t_fir_result res;
            int          k;
            acc_re = 0;
            acc_im = 0;
            for (k = 0; k < NUM_TAPS - 1; k++) window[k] = history[k];
            window[NUM_TAPS-1].re = re;
            window[NUM_TAPS-1].im = im;
            for (k = 0; k < NUM_TAPS; k++) begin
                a = longint'(window[k].re);
                b = longint'(window[k].im);
                c = longint'($signed(coeff[k][31:16]));
                d = longint'($signed(coeff[k][15:0]));
                acc_re += a * c - b * d;
                acc_im += a * d + b * c;
            end
            for (k = 0; k < NUM_TAPS - 1; k++) history[k] = window[k+1];
            part_re = to_q15(acc_re);
            part_im = to_q15(acc_im);
            res.re  = part_re[15:0];
            res.im  = part_im[15:0];
            res.sat = part_re[16] | part_im[16];
            awaited.push_back(res);
        endfunction

        // Prints one line per mismatch and counts every one.
        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // An accepted output: compare it with the oldest queued result.
        task compare_output(logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im,
                            logic sat);
            t_fir_result want;
            if (awaited.size() == 0) begin
                report($sformatf("output %0d,%0d with nothing queued", re, im));
                return;
            end
            want = awaited.pop_front();
            if (re !== want.re)
                report($sformatf("item %0d out_re %0d, want %0d", checked, re, want.re));
            if (im !== want.im)
                report($sformatf("item %0d out_im %0d, want %0d", checked, im, want.im));
            if (sat !== want.sat)
                report($sformatf("item %0d saturated %b, want %b", checked, sat, want.sat));
            checked++;
        endtask

        // Anything still queued at the end of the run never came out.
        task flag_leftover();
            if (awaited.size() != 0)
                report($sformatf("%0d results never arrived", awaited.size()));
        endtask

    endclass

endpackage

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the complex FIR filter testbench: clock, reset, stimulus, stall and
// monitors around complex_fir_filter. Depends on cfir_pkg and cfir_tb_pkg.
module testbench;

    import cfir_pkg::*;
    import cfir_tb_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 240;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx   = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic signed [15:0]      i_sample_re = '0;
    logic signed [15:0]      i_sample_im = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic signed [15:0]      o_out_re;
    logic signed [15:0]      o_out_im;
    logic                    o_saturated;

    fir_scoreboard    sb;
    logic [CFG_W-1:0] tap_plan[TAP_REGS];
    int               gap_pct   = 0;
    int               stall_pct = 0;
    bit               hold_request = 1'b0;
    int               hold_left    = 0;
    int               quiet_cycles = 0;

    complex_fir_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_saturated (o_saturated)
    );

    always #2 i_clk = ~i_clk;

    // Input side: every accepted item goes to the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.take_sample(i_sample_re, i_sample_im);
    end

    // Output side: every accepted item is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.compare_output(o_out_re, o_out_im, o_saturated);
    end

    // Receiver stall: random, or a long hold-off counted here when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one sample, with random idle cycles ahead of it, and wait until it is taken.
    task send_item(int re, int im);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_re <= 16'(re);
        i_sample_im <= 16'(im);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task wait_for_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all taps from tap_plan, then an index beyond the tap file, to be ignored.
    task load_taps();
        int               k;
        int unsigned      stray_idx;
        logic [CFG_W-1:0] stray_data;
        for (k = 0; k < TAP_REGS; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= tap_plan[k];
            @(posedge i_clk);
            sb.write_reg(k, tap_plan[k]);
        end
        stray_idx  = $urandom_range(2 ** CFG_IDX_W - 1, TAP_REGS);
        stray_data = $urandom;
        i_cfg_idx  <= CFG_IDX_W'(stray_idx);
        i_cfg_data <= stray_data;
        @(posedge i_clk);
        sb.write_reg(stray_idx, stray_data);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly full-range values, with extremes and small values mixed in.
    function logic [15:0] random_part();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
            1: return 16'($urandom_range(128)) - 16'd64;
            default: return 16'($urandom);
        endcase
    endfunction

    // Small taps keep most sums in range; wide ones push toward saturation.
    function logic [CFG_W-1:0] random_tap(bit wide);
        logic [15:0] hi, lo;
        if (wide) return $urandom;
        hi = 16'($urandom_range(8191)) - 16'd4096;
        lo = 16'($urandom_range(8191)) - 16'd4096;
        return {hi, lo};
    endfunction

    initial begin
        int phase, n, k;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Taps still at their reset value: extremes must filter to zero.
        send_item(-32768, -32768);
        send_item(32767, 32767);
        send_item(-32768, 32767);
        wait_for_outputs();

        // Every tap at -1-1j: full-scale samples clip the imaginary part at both bounds.
        for (k = 0; k < TAP_REGS; k++) tap_plan[k] = 32'h8000_8000;
        load_taps();
        repeat (4) send_item(-32768, -32768);
        repeat (4) send_item(32767, 32767);
        repeat (2) send_item(-32768, 32767);
        send_item(0, 0);
        send_item(1, -1);
        wait_for_outputs();

        // Only the newest tap set, to 0.5+0.5j: exact halves round toward plus infinity.
        for (k = 0; k < TAP_REGS; k++) tap_plan[k] = '0;
        tap_plan[NUM_TAPS-1] = 32'h4000_4000;
        load_taps();
        send_item(1, 0);
        send_item(-1, 0);
        send_item(0, 1);
        send_item(3, -3);
        send_item(-32768, 0);
        send_item(32767, 32767);
        wait_for_outputs();

        // Random phases, cycling through the idle patterns and several tap settings.
        for (phase = 0; phase < PHASES; phase++) begin
            for (k = 0; k < TAP_REGS; k++) begin
                case (phase)
                    0: tap_plan[k] = 32'h7fff_7fff;
                    1: tap_plan[k] = 32'h8000_8000;
                    2, 3: tap_plan[k] = random_tap(1'b0);
                    default: tap_plan[k] = random_tap(1'($urandom_range(1)));
                endcase
            end
            load_taps();
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 60; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 60; end
                default: begin gap_pct = 14; stall_pct = 14; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Hold the output off long enough for the block to back up into its input.
                if (phase == 2 && n == 100) hold_request = 1'b1;
                // Let the pipeline run dry mid-stream once.
                if (phase == 5 && n == 120) wait_for_outputs();
                send_item(int'(random_part()), int'(random_part()));
            end
            wait_for_outputs();
        end

        sb.flag_leftover();
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
